@@ rtl/core/rtnp_pkg.sv @@
`default_nettype none
package rtnp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_NOTE_LEN = 2'd0;
    localparam logic [1:0] CFG_OCTAVE   = 2'd1;
    localparam logic [1:0] CFG_TEMPO    = 2'd2;

    // configuration reset values
    localparam logic [15:0] RST_NOTE_LEN = 16'd4;
    localparam logic [3:0]  RST_OCTAVE   = 4'd6;
    localparam logic [15:0] RST_TEMPO    = 16'd63;

    // fixed octave offset added to every note
    localparam logic [4:0] OCTAVE_SHIFT = 5'd0;

    // divider geometry: 18 bit dividend, 16 bit divisor
    localparam int          DIV_STEPS   = 18;
    localparam logic [4:0]  DIV_LAST    = 5'(DIV_STEPS - 1);
    localparam logic [17:0] MS_PER_MIN  = 18'd60000;

    // one command from the parser to the timing unit
    typedef struct packed {
        logic        is_tempo;   // tempo field, else a finished note
        logic [15:0] value;      // tempo in bpm, or note length divisor
        logic [3:0]  note_code;
        logic [3:0]  octave;
        logic        dotted;
        logic        tune_end;
    } t_cmd;

    // octave plus fixed shift, saturating at 15
    function automatic logic [3:0] shifted_octave(input logic [3:0] oct);
        logic [4:0] sum;
        sum = {1'b0, oct} + OCTAVE_SHIFT;
        return (sum > 5'd15) ? 4'd15 : sum[3:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rtttl_note_parser_unit.sv @@
`default_nettype none
// RTTTL tune parser. Characters enter one per cycle on the input channel while
// the two-entry command queue has room; a character that ends a note, or a
// tempo field, places one command in the queue. The timing unit behind the
// queue runs an 18-step restoring divider for each note and each nonzero tempo
// field (load, 18 steps, finish); a zero tempo field skips the divider. A note
// is then held in the output register until taken. A note is reported when
// the character after it arrives, or on the terminator 0 with tune_end set.
// Configuration writes are always accepted (ready is always high); index 3 is
// ignored.
module rtttl_note_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_tune_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_note_code,
    output logic [3:0]       o_octave,
    output logic [18:0]      o_duration_ms,
    output logic             o_tune_end,
    output logic             o_tempo_error,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import rtnp_pkg::*;

    logic q_full, q_valid, push, pop;
    t_cmd push_cmd, head_cmd;

    rtnp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_tune_start (i_tune_start),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rtnp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    rtnp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_note_code   (o_note_code),
        .o_octave      (o_octave),
        .o_duration_ms (o_duration_ms),
        .o_tune_end    (o_tune_end),
        .o_tempo_error (o_tempo_error)
    );

endmodule
`default_nettype wire

@@ rtl/core/rtnp_front.sv @@
`default_nettype none
module rtnp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_char_code,
    input  wire logic            i_tune_start,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output rtnp_pkg::t_cmd       o_cmd
);
    import rtnp_pkg::*;

    // parse phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_NAME  = 4'd1;
    localparam logic [3:0] PH_HDR_D = 4'd2;
    localparam logic [3:0] PH_HDR_O = 4'd3;
    localparam logic [3:0] PH_HDR_B = 4'd4;
    localparam logic [3:0] PH_D_NUM = 4'd5;
    localparam logic [3:0] PH_O_DIG = 4'd6;
    localparam logic [3:0] PH_B_NUM = 4'd7;
    localparam logic [3:0] PH_N_NUM = 4'd8;
    localparam logic [3:0] PH_N_SHP = 4'd9;
    localparam logic [3:0] PH_N_DOT = 4'd10;
    localparam logic [3:0] PH_N_OCT = 4'd11;
    localparam logic [3:0] PH_N_COM = 4'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_G  = 8'h67;
    localparam logic [7:0] CH_LO_O  = 8'h6F;

    // accumulate one decimal digit, saturating at 65535
    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] dig);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, dig};
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // note letter to semitone code, anything else is a rest
    function automatic logic [3:0] letter_code(input logic [7:0] ch);
        logic [3:0] code;
        unique case (ch)
            CH_LO_C: code = 4'd1;
            CH_LO_D: code = 4'd3;
            CH_LO_E: code = 4'd5;
            CH_LO_F: code = 4'd6;
            CH_LO_G: code = 4'd8;
            CH_LO_A: code = 4'd10;
            CH_LO_B: code = 4'd12;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

    logic [15:0] r_dflt_len, r_dflt_tempo;
    logic [3:0]  r_dflt_oct;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic        r_skip, n_skip;
    logic [15:0] r_tlen, n_tlen;
    logic [3:0]  r_toct, n_toct;
    logic        r_pv, n_pv;
    logic [3:0]  r_psem, n_psem;
    logic [3:0]  r_poct, n_poct;
    logic [15:0] r_pdiv, n_pdiv;
    logic        r_pdot, n_pdot;

    logic        accept, is_dig, note_char;
    logic [15:0] div_sel;

    assign o_in_ready  = ~i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid & ~i_q_full;
    assign is_dig      = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_len   <= RST_NOTE_LEN;
            r_dflt_oct   <= RST_OCTAVE;
            r_dflt_tempo <= RST_TEMPO;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_NOTE_LEN) r_dflt_len <= i_cfg_data;
            if (i_cfg_index == CFG_OCTAVE)   r_dflt_oct <= i_cfg_data[3:0];
            if (i_cfg_index == CFG_TEMPO)    r_dflt_tempo <= i_cfg_data;
        end
    end

    // character parser
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_skip    = r_skip;
        n_tlen    = r_tlen;
        n_toct    = r_toct;
        n_pv      = r_pv;
        n_psem    = r_psem;
        n_poct    = r_poct;
        n_pdiv    = r_pdiv;
        n_pdot    = r_pdot;
        note_char = 1'b0;
        div_sel   = 16'd1;
        o_push    = 1'b0;
        o_cmd     = '{is_tempo: 1'b0, value: r_pdiv, note_code: r_psem,
                      octave: r_poct, dotted: r_pdot, tune_end: 1'b0};

        if (accept) begin
            // restart on tune start, pending note dropped
            if (i_tune_start) begin
                n_phase = PH_NAME;
                n_acc   = 16'd0;
                n_skip  = 1'b0;
                n_tlen  = r_dflt_len;
                n_toct  = r_dflt_oct;
                n_pv    = 1'b0;
            end

            if (n_phase == PH_IDLE) begin
                n_phase = PH_IDLE;
            end else if (i_char_code == CH_NUL) begin
                // terminator closes any pending note
                if (n_pv) begin
                    o_push         = 1'b1;
                    o_cmd.tune_end = 1'b1;
                    n_pv           = 1'b0;
                end
                n_phase = PH_IDLE;
                n_acc   = 16'd0;
                n_skip  = 1'b0;
            end else if (n_skip && (n_phase < PH_N_NUM)) begin
                n_skip = 1'b0;
            end else begin
                unique case (n_phase)
                    PH_NAME: begin
                        if (i_char_code == CH_COLON) n_phase = PH_HDR_D;
                    end
                    PH_HDR_D, PH_HDR_O, PH_HDR_B: begin
                        if (i_char_code == CH_LO_D && n_phase == PH_HDR_D) begin
                            n_acc   = 16'd0;
                            n_skip  = 1'b1;
                            n_phase = PH_D_NUM;
                        end else if (i_char_code == CH_LO_O && n_phase != PH_HDR_B) begin
                            n_skip  = 1'b1;
                            n_phase = PH_O_DIG;
                        end else if (i_char_code == CH_LO_B) begin
                            n_acc   = 16'd0;
                            n_skip  = 1'b1;
                            n_phase = PH_B_NUM;
                        end else begin
                            o_push         = 1'b1;
                            o_cmd.is_tempo = 1'b1;
                            o_cmd.value    = r_dflt_tempo;
                            n_acc          = 16'd0;
                            n_phase        = PH_N_NUM;
                            note_char      = 1'b1;
                        end
                    end
                    PH_D_NUM: begin
                        if (is_dig) begin
                            n_acc = add_digit(n_acc, i_char_code[3:0]);
                        end else begin
                            if (n_acc != 16'd0) n_tlen = n_acc;
                            n_acc   = 16'd0;
                            n_phase = PH_HDR_O;
                        end
                    end
                    PH_O_DIG: begin
                        if (i_char_code >= CH_THREE && i_char_code <= CH_SEVEN)
                            n_toct = i_char_code[3:0];
                        n_skip  = 1'b1;
                        n_phase = PH_HDR_B;
                    end
                    PH_B_NUM: begin
                        if (is_dig) begin
                            n_acc = add_digit(n_acc, i_char_code[3:0]);
                        end else begin
                            o_push         = 1'b1;
                            o_cmd.is_tempo = 1'b1;
                            o_cmd.value    = n_acc;
                            n_acc          = 16'd0;
                            n_phase        = PH_N_NUM;
                        end
                    end
                    PH_N_SHP, PH_N_DOT, PH_N_OCT, PH_N_COM: begin
                        if (i_char_code == CH_SHARP && n_phase == PH_N_SHP) begin
                            n_psem  = n_psem + 4'd1;
                            n_phase = PH_N_DOT;
                        end else if (i_char_code == CH_DOT && n_phase <= PH_N_DOT) begin
                            n_pdot  = 1'b1;
                            n_phase = PH_N_OCT;
                        end else if (is_dig && n_phase <= PH_N_OCT) begin
                            n_poct  = shifted_octave(i_char_code[3:0]);
                            n_phase = PH_N_COM;
                        end else if (i_char_code == CH_COMMA) begin
                            n_acc   = 16'd0;
                            n_phase = PH_N_NUM;
                        end else begin
                            o_push    = 1'b1;
                            n_pv      = 1'b0;
                            n_acc     = 16'd0;
                            n_phase   = PH_N_NUM;
                            note_char = 1'b1;
                        end
                    end
                    PH_N_NUM: begin
                        if (n_pv) begin
                            o_push = 1'b1;
                            n_pv   = 1'b0;
                        end
                        note_char = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                // duration digit or note letter at a note start
                if (note_char) begin
                    if (is_dig) begin
                        n_acc = add_digit(n_acc, i_char_code[3:0]);
                    end else begin
                        div_sel = (n_acc != 16'd0) ? n_acc : n_tlen;
                        n_pdiv  = (div_sel == 16'd0) ? 16'd1 : div_sel;
                        n_psem  = letter_code(i_char_code);
                        n_poct  = shifted_octave(n_toct);
                        n_pdot  = 1'b0;
                        n_pv    = 1'b1;
                        n_acc   = 16'd0;
                        n_phase = PH_N_SHP;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= 16'd0;
            r_skip  <= 1'b0;
            r_tlen  <= RST_NOTE_LEN;
            r_toct  <= RST_OCTAVE;
            r_pv    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_skip  <= n_skip;
            r_tlen  <= n_tlen;
            r_toct  <= n_toct;
            r_pv    <= n_pv;
        end
    end

    // pending note payload
    always_ff @(posedge i_clk) begin
        r_psem <= n_psem;
        r_poct <= n_poct;
        r_pdiv <= n_pdiv;
        r_pdot <= n_pdot;
    end

endmodule
`default_nettype wire

@@ rtl/core/rtnp_cmd_queue.sv @@
`default_nettype none
module rtnp_cmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rtnp_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output rtnp_pkg::t_cmd       o_cmd
);
    import rtnp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rtnp_back.sv @@
`default_nettype none
module rtnp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire rtnp_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [3:0]           o_note_code,
    output logic [3:0]           o_octave,
    output logic [18:0]          o_duration_ms,
    output logic                 o_tune_end,
    output logic                 o_tempo_error
);
    import rtnp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]  r_state;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem, r_dvsr;
    logic [17:0] r_quo;
    logic [17:0] r_whole;
    logic        r_tzero;
    t_cmd        r_cur;
    logic        r_out_valid;

    logic [16:0] trial;
    logic        ge;
    logic [16:0] diff;
    logic [18:0] len;
    logic        out_free;
    logic        out_load;

    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign out_load    = (r_state == S_FIN) && !r_cur.is_tempo && out_free;

    // one restoring division step
    assign trial = {r_rem, r_quo[17]};
    assign ge    = (trial >= {1'b0, r_dvsr});
    assign diff  = trial - {1'b0, r_dvsr};

    // note length with optional half added for a dot
    assign len = r_cur.dotted ? ({1'b0, r_quo} + {2'b00, r_quo[17:1]}) : {1'b0, r_quo};

    // sequencer, divider and tempo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_whole     <= 18'd0;
            r_tzero     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cur  <= i_cmd;
                        r_rem  <= 16'd0;
                        r_dvsr <= i_cmd.value;
                        r_cnt  <= 5'd0;
                        r_quo  <= i_cmd.is_tempo ? MS_PER_MIN : r_whole;
                        if (i_cmd.is_tempo && i_cmd.value == 16'd0) begin
                            r_whole <= 18'd0;
                            r_tzero <= 1'b1;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? diff[15:0] : trial[15:0];
                    r_quo <= {r_quo[16:0], ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_cur.is_tempo) begin
                        r_whole <= {r_quo[15:0], 2'b00};
                        r_tzero <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_note_code   <= r_cur.note_code;
            o_octave      <= r_cur.octave;
            o_duration_ms <= r_tzero ? 19'd0 : len;
            o_tune_end    <= r_cur.tune_end;
            o_tempo_error <= r_tzero;
        end
    end

endmodule
`default_nettype wire
